>>> src/rme_pkg.sv
// Shared types and constants of the register machine execute block.
package rme_pkg;

  localparam int unsigned ACTION_W  = 4;
  localparam int unsigned REG_IDX_W = 5;
  localparam int unsigned IMM_W     = 32;
  localparam int unsigned VALUE_W   = 32;

  typedef enum logic [ACTION_W-1:0] {
    ACT_IN   = 4'd0,
    ACT_OUT  = 4'd1,
    ACT_MOV  = 4'd2,
    ACT_XCHG = 4'd3,
    ACT_ADD  = 4'd4,
    ACT_SUB  = 4'd5,
    ACT_MUL  = 4'd6,
    ACT_DIV  = 4'd7,
    ACT_MOD  = 4'd8,
    ACT_AND  = 4'd9,
    ACT_OR   = 4'd10,
    ACT_XOR  = 4'd11
  } action_e;

  typedef enum logic [2:0] {
    WR_IMM  = 3'd0,
    WR_A    = 3'd1,
    WR_B    = 3'd2,
    WR_ALU  = 3'd3,
    WR_ITER = 3'd4
  } wr_sel_e;

  // Controller to datapath
  typedef struct packed {
    logic    load;      // capture the instruction, read both operands
    logic    wr_en;     // write the register file
    wr_sel_e wr_sel;
    logic    wr_s1;     // write to the first source instead of the destination
    logic    start;     // set up the shift-add / shift-subtract unit
    logic    step;      // one iteration of that unit
    logic    post;      // load the output register
    logic    post_err;  // posted word is a divide-by-zero error
  } rme_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic                b_zero;
    logic                out_free;
    logic                last;
  } rme_stat_t;

endpackage

>>> src/rme_ram.sv
// Generic RAM: one write port, two registered read ports.
module rme_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 26
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

>>> src/rme_datapath.sv
// Datapath: register file, operand and ALU logic, iterative mul/div unit, output register.
module rme_datapath #(
  parameter int unsigned NUM_REGS   = 26,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  rme_pkg::rme_cmd_t                   cmd_i,
  output rme_pkg::rme_stat_t                  stat_o,
  input  logic [rme_pkg::ACTION_W-1:0]        action_i,
  input  logic [rme_pkg::REG_IDX_W-1:0]       dest_reg_i,
  input  logic [rme_pkg::REG_IDX_W-1:0]       first_src_i,
  input  logic [rme_pkg::REG_IDX_W-1:0]       second_src_i,
  input  logic                                three_operands_i,
  input  logic signed [rme_pkg::IMM_W-1:0]    immediate_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                status_o,
  output logic signed [rme_pkg::VALUE_W-1:0]  value_o
);
  import rme_pkg::*;

  localparam int unsigned DW    = DATA_WIDTH;
  localparam int unsigned AW    = $clog2(NUM_REGS);
  localparam int unsigned CNT_W = $clog2(DATA_WIDTH);
  localparam logic [REG_IDX_W:0] NUM_IDX = (REG_IDX_W+1)'(NUM_REGS);

  // Instruction captured at accept
  logic [ACTION_W-1:0]  action_q;
  logic [REG_IDX_W-1:0] d_q, s1_q;
  logic [IMM_W-1:0]     imm_q;
  logic                 ok_a_q, ok_b_q;

  // Register file and its valid bits
  logic [NUM_REGS-1:0]  valid_q;
  logic [REG_IDX_W-1:0] raddr_a, raddr_b, waddr;
  logic                 alu_in, ok_a_d, ok_b_d, w_in_range, ram_we;
  logic [DW-1:0]        rdata_a, rdata_b, op_a, op_b, wdata, alu_res, imm_ext;

  // Iterative unit
  logic [DW-1:0]    acc_q, x_q, y_q, iter_res, mag_a, mag_b;
  logic [CNT_W-1:0] cnt_q;
  logic             neg_q_q, neg_r_q;
  logic [DW:0]      div_sh, div_diff;

  // Output register
  logic                out_valid_q, status_q;
  logic [VALUE_W-1:0]  value_q, out_val;

  // Three-operand ALU reads both sources; everything else reads dest and first source
  assign alu_in  = (action_i >= ACT_ADD) && (action_i <= ACT_XOR) && three_operands_i;
  assign raddr_a = alu_in ? first_src_i  : dest_reg_i;
  assign raddr_b = alu_in ? second_src_i : first_src_i;
  assign ok_a_d  = ({1'b0, raddr_a} < NUM_IDX) && valid_q[raddr_a[AW-1:0]];
  assign ok_b_d  = ({1'b0, raddr_b} < NUM_IDX) && valid_q[raddr_b[AW-1:0]];

  assign waddr      = cmd_i.wr_s1 ? s1_q : d_q;
  assign w_in_range = {1'b0, waddr} < NUM_IDX;
  assign ram_we     = cmd_i.wr_en && w_in_range;

  rme_ram #(
    .WIDTH (DW),
    .DEPTH (NUM_REGS)
  ) u_regfile (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (waddr[AW-1:0]),
    .wdata_i   (wdata),
    .re_i      (cmd_i.load),
    .raddr_a_i (raddr_a[AW-1:0]),
    .raddr_b_i (raddr_b[AW-1:0]),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  // Never-written or out-of-range registers read as zero
  assign op_a = ok_a_q ? rdata_a : '0;
  assign op_b = ok_b_q ? rdata_b : '0;

  generate
    if (DW > VALUE_W) begin : g_wide
      assign imm_ext = {{(DW-IMM_W){imm_q[IMM_W-1]}}, imm_q};
      assign out_val = op_a[VALUE_W-1:0];
    end else if (DW == VALUE_W) begin : g_equal
      assign imm_ext = imm_q;
      assign out_val = op_a;
    end else begin : g_narrow
      assign imm_ext = imm_q[DW-1:0];
      assign out_val = {{(VALUE_W-DW){op_a[DW-1]}}, op_a};
    end
  endgenerate

  always_comb begin
    case (action_q)
      ACT_ADD: alu_res = op_a + op_b;
      ACT_SUB: alu_res = op_a - op_b;
      ACT_AND: alu_res = op_a & op_b;
      ACT_OR:  alu_res = op_a | op_b;
      default: alu_res = op_a ^ op_b;
    endcase
  end

  assign mag_a = op_a[DW-1] ? (DW'(0) - op_a) : op_a;
  assign mag_b = op_b[DW-1] ? (DW'(0) - op_b) : op_b;

  // Restoring division: shift next dividend bit into the partial remainder
  assign div_sh   = {acc_q, y_q[DW-1]};
  assign div_diff = div_sh - {1'b0, x_q};

  always_comb begin
    case (action_q)
      ACT_MUL: iter_res = acc_q;
      ACT_DIV: iter_res = neg_q_q ? (DW'(0) - y_q) : y_q;
      default: iter_res = neg_r_q ? (DW'(0) - acc_q) : acc_q;
    endcase
  end

  always_comb begin
    case (cmd_i.wr_sel)
      WR_IMM:  wdata = imm_ext;
      WR_A:    wdata = op_a;
      WR_B:    wdata = op_b;
      WR_ALU:  wdata = alu_res;
      WR_ITER: wdata = iter_res;
      default: wdata = op_b;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      action_q <= action_i;
      d_q      <= dest_reg_i;
      s1_q     <= first_src_i;
      imm_q    <= immediate_i;
      ok_a_q   <= ok_a_d;
      ok_b_q   <= ok_b_d;
    end
    if (cmd_i.start) begin
      acc_q <= '0;
      cnt_q <= CNT_W'(DATA_WIDTH - 1);
      if (action_q == ACT_MUL) begin
        x_q <= op_a;
        y_q <= op_b;
      end else begin
        x_q     <= mag_b;
        y_q     <= mag_a;
        neg_q_q <= op_a[DW-1] ^ op_b[DW-1];
        neg_r_q <= op_a[DW-1];
      end
    end else if (cmd_i.step) begin
      cnt_q <= cnt_q - CNT_W'(1);
      if (action_q == ACT_MUL) begin
        acc_q <= acc_q + (y_q[0] ? x_q : '0);
        x_q   <= {x_q[DW-2:0], 1'b0};
        y_q   <= {1'b0, y_q[DW-1:1]};
      end else if (!div_diff[DW]) begin
        acc_q <= div_diff[DW-1:0];
        y_q   <= {y_q[DW-2:0], 1'b1};
      end else begin
        acc_q <= div_sh[DW-1:0];
        y_q   <= {y_q[DW-2:0], 1'b0};
      end
    end
    if (cmd_i.post) begin
      status_q <= cmd_i.post_err;
      value_q  <= cmd_i.post_err ? '0 : out_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (ram_we) begin
        valid_q[waddr[AW-1:0]] <= 1'b1;
      end
      if (cmd_i.post) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign stat_o.action   = action_q;
  assign stat_o.b_zero   = (op_b == '0);
  assign stat_o.out_free = !out_valid_q || !out_stall_i;
  assign stat_o.last     = (cnt_q == '0);

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign value_o     = value_q;

`ifndef ASSERT_OFF
  a_post_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.post |-> !(out_valid_q && out_stall_i))
    else $error("result posted over an unaccepted word");
  a_no_wr_on_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.load && cmd_i.wr_en))
    else $error("register write collides with operand read");
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o) |-> (value_o == '0))
    else $error("error word carries a nonzero value");
  a_held_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(value_o)))
    else $error("stalled output word changed");
`endif

endmodule

>>> src/rme_ctrl.sv
// Controller: sequences each instruction through the datapath.
module rme_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  output rme_pkg::rme_cmd_t  cmd_o,
  input  rme_pkg::rme_stat_t stat_i
);
  import rme_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_XCHG,
    ST_ITER,
    ST_DONE
  } state_e;

  state_e   state_q, state_d;
  rme_cmd_t cmd;

  always_comb begin
    cmd     = '0;
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd.load = 1'b1;
          state_d  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_d = ST_IDLE;
        case (stat_i.action)
          ACT_IN: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = WR_IMM;
          end
          ACT_OUT: begin
            // hold until the output register can take the word
            if (stat_i.out_free) begin
              cmd.post = 1'b1;
            end else begin
              state_d = ST_EXEC;
            end
          end
          ACT_MOV: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = WR_B;
          end
          ACT_XCHG: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = WR_B;
            state_d    = ST_XCHG;
          end
          ACT_ADD, ACT_SUB, ACT_AND, ACT_OR, ACT_XOR: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = WR_ALU;
          end
          ACT_MUL: begin
            cmd.start = 1'b1;
            state_d   = ST_ITER;
          end
          ACT_DIV, ACT_MOD: begin
            if (!stat_i.b_zero) begin
              cmd.start = 1'b1;
              state_d   = ST_ITER;
            end else if (stat_i.out_free) begin
              cmd.post     = 1'b1;
              cmd.post_err = 1'b1;
            end else begin
              state_d = ST_EXEC;
            end
          end
          default: begin
            // unused codes: drop the item
          end
        endcase
      end
      ST_XCHG: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WR_A;
        cmd.wr_s1  = 1'b1;
        state_d    = ST_IDLE;
      end
      ST_ITER: begin
        cmd.step = 1'b1;
        if (stat_i.last) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WR_ITER;
        state_d    = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);
  assign cmd_o      = cmd;

`ifndef ASSERT_OFF
  a_step_in_iter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.step |-> (state_q == ST_ITER))
    else $error("iteration step outside the iterate state");
  a_start_iter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.start |=> (state_q == ST_ITER))
    else $error("unit started without entering the iterate state");
  a_xchg_follow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_XCHG) |-> ($past(state_q) == ST_EXEC))
    else $error("second exchange write without its first");
`endif

endmodule

>>> src/register_machine_execute_top.sv
// Top level of the register machine execute block.
// Sequencing: a word is taken in the idle state, then executed; in, mov and ALU ops
// other than mul/div/mod write on execute, xchg writes again in a second state, out and
// div/mod by zero post a word (held while the output register holds an unaccepted word),
// mul/div/mod otherwise run DATA_WIDTH shift-add or shift-subtract steps, one per cycle.
// Throughput: one instruction at a time; the next word is taken when the previous retires.
// Reset: all registers read as zero through per-entry valid bits; no clearing pass needed.
module register_machine_execute_top #(
  parameter int unsigned NUM_REGS   = 26,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // instruction channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [rme_pkg::ACTION_W-1:0]        action_i,
  input  logic [rme_pkg::REG_IDX_W-1:0]       dest_reg_i,
  input  logic [rme_pkg::REG_IDX_W-1:0]       first_src_i,
  input  logic [rme_pkg::REG_IDX_W-1:0]       second_src_i,
  input  logic                                three_operands_i,
  input  logic signed [rme_pkg::IMM_W-1:0]    immediate_i,
  // result channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                status_o,
  output logic signed [rme_pkg::VALUE_W-1:0]  value_o
);
  import rme_pkg::*;

  rme_cmd_t  cmd;
  rme_stat_t stat;

  // Controller: decides per instruction which writes, iterations and posts happen
  rme_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd),
    .stat_i     (stat)
  );

  // Datapath: register file, operand masking, ALU, iterative unit, output register.
  // The output register separates the result channel from the instruction channel,
  // so a stalled result word holds while new instructions that post nothing proceed.
  rme_datapath #(
    .NUM_REGS   (NUM_REGS),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .action_i         (action_i),
    .dest_reg_i       (dest_reg_i),
    .first_src_i      (first_src_i),
    .second_src_i     (second_src_i),
    .three_operands_i (three_operands_i),
    .immediate_i      (immediate_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_o         (status_o),
    .value_o          (value_o)
  );

endmodule

>>> test/rme_exec_checker.sv
// Instruction-stream predictor and result checker for the register machine execute block.
`timescale 1ns / 100ps

module rme_exec_checker #(
  parameter int unsigned NUM_REGS = 26
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  input  logic                             in_stall_i,
  input  logic [rme_pkg::ACTION_W-1:0]     action_i,
  input  logic [rme_pkg::REG_IDX_W-1:0]    dest_reg_i,
  input  logic [rme_pkg::REG_IDX_W-1:0]    first_src_i,
  input  logic [rme_pkg::REG_IDX_W-1:0]    second_src_i,
  input  logic                             three_operands_i,
  input  logic [rme_pkg::IMM_W-1:0]        immediate_i,
  input  logic                             out_valid_i,
  input  logic                             out_stall_i,
  input  logic                             status_i,
  input  logic [rme_pkg::VALUE_W-1:0]      value_i,
  output int unsigned                      mismatch_cnt_o,
  output int unsigned                      pending_cnt_o
);
  import rme_pkg::*;

  typedef struct packed {
    logic               status;
    logic [VALUE_W-1:0] value;
  } out_word_t;

  logic [VALUE_W-1:0] reg_file [NUM_REGS];
  out_word_t          pending_words [$];

  function automatic logic [VALUE_W-1:0] read_reg(input logic [REG_IDX_W-1:0] idx);
    if (idx >= NUM_REGS) return '0;
    return reg_file[idx];
  endfunction

  function automatic void write_reg(input logic [REG_IDX_W-1:0] idx,
                                    input logic [VALUE_W-1:0] val);
    if (idx < NUM_REGS) reg_file[idx] = val;
  endfunction

  // Execute one instruction on the shadow register file; return 1 if it posts a word.
  function automatic bit execute_instr(input logic [ACTION_W-1:0] act,
                                       input logic [REG_IDX_W-1:0] d,
                                       input logic [REG_IDX_W-1:0] s1,
                                       input logic [REG_IDX_W-1:0] s2,
                                       input logic three,
                                       input logic [IMM_W-1:0] imm,
                                       output out_word_t word);
    logic [VALUE_W-1:0] a, b, r, ma, mb, q, m, t;
    bit                 na, nb;
    word = '0;
    case (act)
      ACT_IN: begin
        write_reg(d, imm);
        return 0;
      end
      ACT_OUT: begin
        word.value = read_reg(d);
        return 1;
      end
      ACT_MOV: begin
        write_reg(d, read_reg(s1));
        return 0;
      end
      ACT_XCHG: begin
        t = read_reg(d);
        write_reg(d, read_reg(s1));
        write_reg(s1, t);
        return 0;
      end
      ACT_ADD, ACT_SUB, ACT_MUL, ACT_DIV, ACT_MOD, ACT_AND, ACT_OR, ACT_XOR: begin
        a = three ? read_reg(s1) : read_reg(d);
        b = three ? read_reg(s2) : read_reg(s1);
        r = '0;
        case (act)
          ACT_ADD: r = a + b;
          ACT_SUB: r = a - b;
          ACT_MUL: r = a * b;
          ACT_AND: r = a & b;
          ACT_OR:  r = a | b;
          ACT_XOR: r = a ^ b;
          default: begin
            // divide by zero: error word, destination untouched
            if (b == '0) begin
              word.status = 1'b1;
              return 1;
            end
            // unsigned magnitudes keep most-negative / -1 well defined
            na = a[VALUE_W-1];
            nb = b[VALUE_W-1];
            ma = na ? -a : a;
            mb = nb ? -b : b;
            q  = ma / mb;
            m  = ma % mb;
            if (act == ACT_DIV) r = (na != nb) ? -q : q;
            else r = na ? -m : m;
          end
        endcase
        write_reg(d, r);
        return 0;
      end
      default: return 0;
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_word_t got, want;
    if (!rst_ni) begin
      foreach (reg_file[i]) reg_file[i] = '0;
      pending_words.delete();
      mismatch_cnt_o <= 0;
      pending_cnt_o  <= 0;
    end else begin
      // check the outgoing word before taking in this edge's instruction
      if (out_valid_i === 1'b1 && out_stall_i === 1'b0) begin
        got = {status_i, value_i};
        if (pending_words.size() == 0) begin
          if (mismatch_cnt_o < 10)
            $display("%0t: unexpected word status=%0b value=%h", $realtime, got.status,
                     got.value);
          mismatch_cnt_o <= mismatch_cnt_o + 1;
        end else begin
          want = pending_words.pop_front();
          if (got.status !== want.status || got.value !== want.value) begin
            if (mismatch_cnt_o < 10)
              $display("%0t: word mismatch status exp=%0b got=%0b value exp=%h got=%h",
                       $realtime, want.status, got.status, want.value, got.value);
            mismatch_cnt_o <= mismatch_cnt_o + 1;
          end
        end
      end
      if (in_valid_i === 1'b1 && in_stall_i === 1'b0) begin
        if (execute_instr(action_i, dest_reg_i, first_src_i, second_src_i,
                          three_operands_i, immediate_i, want))
          pending_words.push_back(want);
      end
      pending_cnt_o <= pending_words.size();
    end
  end

endmodule

>>> test/tb_register_machine_execute_top.sv
// Testbench top: stimulus, flow control and verdict for register_machine_execute_top.
`timescale 1ns / 100ps

module tb_register_machine_execute_top;
  import rme_pkg::*;

  // Action codes the block must ignore
  localparam logic [ACTION_W-1:0] ACT_SPARE_LO = 4'd12;
  localparam logic [ACTION_W-1:0] ACT_SPARE_HI = 4'd15;

  localparam int unsigned ITEMS_PER_PHASE = 460;
  localparam int unsigned CYCLE_LIMIT     = 1000000;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned TAIL_CYCLES     = 48;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic [ACTION_W-1:0]  action_i;
  logic [REG_IDX_W-1:0] dest_reg_i;
  logic [REG_IDX_W-1:0] first_src_i;
  logic [REG_IDX_W-1:0] second_src_i;
  logic                 three_operands_i;
  logic [IMM_W-1:0]     immediate_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic                 status_o;
  logic [VALUE_W-1:0]   value_o;

  int unsigned mismatch_cnt;
  int unsigned pending_cnt;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned hold_cycles;
  int unsigned cycle_cnt;

  register_machine_execute_top dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .action_i         (action_i),
    .dest_reg_i       (dest_reg_i),
    .first_src_i      (first_src_i),
    .second_src_i     (second_src_i),
    .three_operands_i (three_operands_i),
    .immediate_i      (immediate_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_o         (status_o),
    .value_o          (value_o)
  );

  // Watches both channels, predicts every posted word and reports the mismatch count
  rme_exec_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .action_i         (action_i),
    .dest_reg_i       (dest_reg_i),
    .first_src_i      (first_src_i),
    .second_src_i     (second_src_i),
    .three_operands_i (three_operands_i),
    .immediate_i      (immediate_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_i         (status_o),
    .value_i          (value_o),
    .mismatch_cnt_o   (mismatch_cnt),
    .pending_cnt_o    (pending_cnt)
  );

  // 2 ns clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Hard stop: far above the slowest legal run (every word a mul/div plus both sides idling
  // 85 percent of the time, plus the long receiver hold-off).
  initial cycle_cnt = 0;
  always @(posedge clk_i) begin
    cycle_cnt = cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("register_machine_execute_top verification failed");
      $finish;
    end
  end

  // Receiver: random stall at the falling edge, or a long hold-off when one is requested.
  // The hold-off is counted here so the sender keeps offering words meanwhile.
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold_cycles) @(negedge clk_i);
        hold_cycles = 0;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // Offer one instruction word: idle at random first, then hold it until accepted.
  // Valid gets exactly one nonblocking update per falling edge.
  task automatic put_word(input logic [ACTION_W-1:0] act, input logic [REG_IDX_W-1:0] d,
                          input logic [REG_IDX_W-1:0] s1, input logic [REG_IDX_W-1:0] s2,
                          input logic three, input logic [IMM_W-1:0] imm);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i       <= 1'b1;
    action_i         <= act;
    dest_reg_i       <= d;
    first_src_i      <= s1;
    second_src_i     <= s2;
    three_operands_i <= three;
    immediate_i      <= imm;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // Drop valid and wait until every predicted word has come out
  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_cnt != 0) @(negedge clk_i);
  endtask

  // Mostly the named registers, clustered low so results feed later operands;
  // now and then an index past the file, which reads zero and drops writes.
  function automatic logic [REG_IDX_W-1:0] pick_reg();
    case ($urandom_range(15))
      0:       return REG_IDX_W'($urandom_range(31, 26));
      1, 2, 3, 4, 5, 6, 7: return REG_IDX_W'($urandom_range(5));
      default: return REG_IDX_W'($urandom_range(25));
    endcase
  endfunction

  // Random instruction stream; ignored action codes do not count toward n.
  task automatic run_random(input int unsigned n);
    int unsigned          done;
    int unsigned          sel;
    logic [ACTION_W-1:0]  act;
    logic [IMM_W-1:0]     imm;
    done = 0;
    while (done < n) begin
      sel = $urandom_range(99);
      if (sel < 4) act = ACT_SPARE_LO + ACTION_W'($urandom_range(3));
      else if (sel < 22) act = ACT_IN;
      else if (sel < 38) act = ACT_OUT;
      else act = ACT_MOV + ACTION_W'($urandom_range(ACT_XOR - ACT_MOV));
      // immediates favor zero, small and extreme values to hit the divide corners
      case ($urandom_range(5))
        0:       imm = $urandom();
        1:       imm = $urandom_range(16) - 8;
        2:       imm = '0;
        3:       imm = $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        4:       imm = 32'hFFFF_FFFF;
        default: imm = $urandom() >> $urandom_range(31);
      endcase
      put_word(act, pick_reg(), pick_reg(), pick_reg(), 1'($urandom_range(1)), imm);
      if (act <= ACT_XOR) done = done + 1;
    end
  endtask

  initial begin
    rst_ni           = 1'b0;
    in_valid_i       = 1'b0;
    action_i         = ACT_IN;
    dest_reg_i       = '0;
    first_src_i      = '0;
    second_src_i     = '0;
    three_operands_i = 1'b0;
    immediate_i      = '0;
    send_idle_pct    = 0;
    recv_idle_pct    = 0;
    hold_cycles      = 0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: extremes, every operation, and the corner cases
    put_word(ACT_IN,   0,  0,  0, 1'b0, 32'h7FFF_FFFF);  // A = max
    put_word(ACT_IN,   1,  0,  0, 1'b0, 32'h8000_0000);  // B = min
    put_word(ACT_IN,   2,  0,  0, 1'b0, 32'hFFFF_FFFF);  // C = -1
    put_word(ACT_IN,   25, 0,  0, 1'b0, 32'd7);          // Z = 7
    put_word(ACT_OUT,  0,  0,  0, 1'b0, '0);
    put_word(ACT_DIV,  4,  1,  2, 1'b1, '0);             // min / -1 stays min
    put_word(ACT_MOD,  5,  1,  2, 1'b1, '0);             // min mod -1 is zero
    put_word(ACT_OUT,  4,  0,  0, 1'b0, '0);
    put_word(ACT_OUT,  5,  0,  0, 1'b0, '0);
    put_word(ACT_DIV,  0,  3,  0, 1'b0, '0);             // divide by zero, A kept
    put_word(ACT_MOD,  6,  0,  3, 1'b1, '0);             // modulo by zero
    put_word(ACT_MUL,  0,  0,  0, 1'b0, '0);             // max * max wraps
    put_word(ACT_ADD,  7,  0,  1, 1'b1, '0);
    put_word(ACT_SUB,  7,  25, 0, 1'b0, '0);
    put_word(ACT_AND,  8,  7,  2, 1'b1, '0);
    put_word(ACT_OR,   8,  25, 0, 1'b0, '0);
    put_word(ACT_XOR,  8,  7,  0, 1'b0, '0);
    put_word(ACT_MOV,  9,  25, 0, 1'b0, '0);
    put_word(ACT_XCHG, 9,  1,  0, 1'b0, '0);
    put_word(ACT_XCHG, 9,  9,  0, 1'b0, '0);             // exchange with itself
    put_word(ACT_IN,   31, 0,  0, 1'b0, 32'd5);          // write past the file, dropped
    put_word(ACT_MOV,  0,  31, 0, 1'b0, '0);             // read past the file gives zero
    put_word(ACT_DIV,  7,  25, 0, 1'b0, '0);             // negative dividend truncates
    put_word(ACT_SPARE_HI, 5'h1F, 5'h1F, 5'h1F, 1'b1, 32'hFFFF_FFFF);  // ignored
    put_word(ACT_OUT,  7,  0,  0, 1'b0, '0);
    put_word(ACT_OUT,  9,  0,  0, 1'b0, '0);
    put_word(ACT_OUT,  31, 0,  0, 1'b0, '0);
    drain_results();

    // Sender mostly busy, receiver mostly stalling
    send_idle_pct = 15;
    recv_idle_pct = 85;
    run_random(ITEMS_PER_PHASE);
    drain_results();

    // The other way round
    send_idle_pct = 85;
    recv_idle_pct = 15;
    run_random(ITEMS_PER_PHASE);
    drain_results();

    // No idling; start with a long receiver hold-off while out words keep coming,
    // so the output register fills and the block stalls its input
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_cycles   = HOLD_OFF_CYCLES;
    repeat (12) put_word(ACT_OUT, pick_reg(), '0, '0, 1'b0, '0);
    run_random(ITEMS_PER_PHASE);
    drain_results();

    // let any result-free instruction still in flight retire
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (mismatch_cnt == 0 && pending_cnt == 0) begin
      $display("register_machine_execute_top verification clean");
    end else begin
      $display("register_machine_execute_top verification failed");
    end
    $finish;
  end

endmodule

>>> sim.f
src/rme_pkg.sv
src/rme_ram.sv
src/rme_datapath.sv
src/rme_ctrl.sv
src/register_machine_execute_top.sv
test/rme_exec_checker.sv
test/tb_register_machine_execute_top.sv
